>>> src/djp_pkg.sv
// Shared constants, types and tables for the delta passive joint angle block.
// CORDIC arctangent table, arm frame coefficients, register map.
// No dependencies.
package djp_pkg;

  localparam int CORDIC_STEPS_DEF  = 16;
  localparam int POSITION_BITS_DEF = 24;

  // angle accumulator width, radians * 2^30
  localparam int ZW = 35;
  // sin/cos datapath width
  localparam int XW = 33;

  localparam logic signed [ZW-1:0] PI_Q30       = 35'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30  = 35'sd1686629713;
  localparam logic signed [XW-1:0] ROT_GAIN_Q30 = 33'sd652032874;
  localparam logic signed [17:0]   VEC_GAIN_Q16 = 18'sd107922;

  // register map, word index
  localparam logic [1:0] REG_UPPER_ARM  = 2'd0;
  localparam logic [1:0] REG_PLATFORM   = 2'd1;
  localparam logic [1:0] REG_BASE       = 2'd2;
  localparam logic [1:0] REG_MOTOR_ZOFF = 2'd3;

  localparam logic [22:0] UPPER_ARM_RST  = 23'd182849;
  localparam logic [22:0] PLATFORM_RST   = 23'd47186;
  localparam logic [22:0] BASE_RST       = 23'd123857;
  localparam logic [23:0] MOTOR_ZOFF_RST = 24'hFF999A; // -26214

  // geometry registers handed to the lanes
  typedef struct packed {
    logic [22:0]        rf;
    logic [22:0]        e;
    logic [22:0]        f;
    logic signed [23:0] zoff;
  } geom_t;

  // pipeline depth of one lane
  function automatic int lane_latency(input int steps);
    return 3 * steps + 7;
  endfunction

  // arctangent of 2^-i, radians * 2^30
  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:       r = 35'sd843314857;
      1:       r = 35'sd497837829;
      2:       r = 35'sd263043837;
      3:       r = 35'sd133525159;
      4:       r = 35'sd67021687;
      5:       r = 35'sd33543516;
      6:       r = 35'sd16775851;
      7:       r = 35'sd8388437;
      8:       r = 35'sd4194283;
      9:       r = 35'sd2097149;
      10:      r = 35'sd1048576;
      11:      r = 35'sd524288;
      12:      r = 35'sd262144;
      13:      r = 35'sd131072;
      14:      r = 35'sd65536;
      15:      r = 35'sd32768;
      16:      r = 35'sd16384;
      17:      r = 35'sd8192;
      18:      r = 35'sd4096;
      19:      r = 35'sd2048;
      20:      r = 35'sd1024;
      21:      r = 35'sd512;
      22:      r = 35'sd256;
      23:      r = 35'sd128;
      default: r = '0;
    endcase
    return r;
  endfunction

  // cos of arm angle (-90, 30, 150 deg), Q30
  function automatic logic signed [31:0] arm_cos(input int k);
    logic signed [31:0] r;
    case (k)
      0:       r = 32'sd0;
      1:       r = 32'sd929887697;
      2:       r = -32'sd929887697;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  // sin of arm angle, Q30
  function automatic logic signed [31:0] arm_sin(input int k);
    logic signed [31:0] r;
    case (k)
      0:       r = -32'sd1073741824;
      1:       r = 32'sd536870912;
      2:       r = 32'sd536870912;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

>>> src/djp_rot.sv
// Pipelined rotation CORDIC: sin and cos of a Q30 angle, one stage per step.
// Folds the angle into [-pi/2, pi/2] first. Uses djp_pkg.
module djp_rot #(
  parameter int STEPS = djp_pkg::CORDIC_STEPS_DEF,
  parameter int SW    = 8
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [djp_pkg::ZW-1:0] ang,
  input  logic [SW-1:0]                 side_in,
  output logic signed [djp_pkg::XW-1:0] cos_o,
  output logic signed [djp_pkg::XW-1:0] sin_o,
  output logic [SW-1:0]                 side_out
);

  logic signed [djp_pkg::XW-1:0] xr [0:STEPS];
  logic signed [djp_pkg::XW-1:0] yr [0:STEPS];
  logic signed [djp_pkg::ZW-1:0] zr [0:STEPS];
  logic                          neg [0:STEPS];
  logic [SW-1:0]                 sd [0:STEPS];

  // fold stage
  always_ff @(posedge clk) begin
    if (en) begin
      xr[0] <= djp_pkg::ROT_GAIN_Q30;
      yr[0] <= '0;
      sd[0] <= side_in;
      if (ang > djp_pkg::HALF_PI_Q30) begin
        zr[0]  <= ang - djp_pkg::PI_Q30;
        neg[0] <= 1'b1;
      end else if (ang < -djp_pkg::HALF_PI_Q30) begin
        zr[0]  <= ang + djp_pkg::PI_Q30;
        neg[0] <= 1'b1;
      end else begin
        zr[0]  <= ang;
        neg[0] <= 1'b0;
      end
    end
  end

  // one micro-rotation per stage
  for (genvar k = 1; k <= STEPS; k++) begin : g_step
    localparam logic signed [djp_pkg::ZW-1:0] ATN = djp_pkg::atan_q30(k - 1);
    always_ff @(posedge clk) begin
      if (en) begin
        neg[k] <= neg[k-1];
        sd[k]  <= sd[k-1];
        if (zr[k-1] >= 0) begin
          xr[k] <= xr[k-1] - (yr[k-1] >>> (k - 1));
          yr[k] <= yr[k-1] + (xr[k-1] >>> (k - 1));
          zr[k] <= zr[k-1] - ATN;
        end else begin
          xr[k] <= xr[k-1] + (yr[k-1] >>> (k - 1));
          yr[k] <= yr[k-1] - (xr[k-1] >>> (k - 1));
          zr[k] <= zr[k-1] + ATN;
        end
      end
    end
  end

  assign cos_o    = neg[STEPS] ? -xr[STEPS] : xr[STEPS];
  assign sin_o    = neg[STEPS] ? -yr[STEPS] : yr[STEPS];
  assign side_out = sd[STEPS];

endmodule

>>> src/djp_vec.sv
// Pipelined vectoring CORDIC: atan2(y, x) in Q30 and the gain-scaled magnitude.
// Negative x is mirrored with a +-pi offset; a zero vector gives zeros. Uses djp_pkg.
module djp_vec #(
  parameter int STEPS = djp_pkg::CORDIC_STEPS_DEF,
  parameter int VW    = 32,
  parameter int SW    = 8
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [VW-1:0]          x_in,
  input  logic signed [VW-1:0]          y_in,
  input  logic [SW-1:0]                 side_in,
  output logic signed [djp_pkg::ZW-1:0] ang_o,
  output logic signed [VW-1:0]          mag_o,
  output logic [SW-1:0]                 side_out
);

  logic signed [VW-1:0]          xr [0:STEPS];
  logic signed [VW-1:0]          yr [0:STEPS];
  logic signed [djp_pkg::ZW-1:0] zr [0:STEPS];
  logic                          zero [0:STEPS];
  logic [SW-1:0]                 sd [0:STEPS];

  // half-plane mirror stage
  always_ff @(posedge clk) begin
    if (en) begin
      sd[0]   <= side_in;
      zero[0] <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        xr[0] <= -x_in;
        yr[0] <= -y_in;
        zr[0] <= (y_in >= 0) ? djp_pkg::PI_Q30 : -djp_pkg::PI_Q30;
      end else begin
        xr[0] <= x_in;
        yr[0] <= y_in;
        zr[0] <= '0;
      end
    end
  end

  // drive y toward zero, one step per stage
  for (genvar k = 1; k <= STEPS; k++) begin : g_step
    localparam logic signed [djp_pkg::ZW-1:0] ATN = djp_pkg::atan_q30(k - 1);
    always_ff @(posedge clk) begin
      if (en) begin
        zero[k] <= zero[k-1];
        sd[k]   <= sd[k-1];
        if (yr[k-1] >= 0) begin
          xr[k] <= xr[k-1] + (yr[k-1] >>> (k - 1));
          yr[k] <= yr[k-1] - (xr[k-1] >>> (k - 1));
          zr[k] <= zr[k-1] + ATN;
        end else begin
          xr[k] <= xr[k-1] - (yr[k-1] >>> (k - 1));
          yr[k] <= yr[k-1] + (xr[k-1] >>> (k - 1));
          zr[k] <= zr[k-1] - ATN;
        end
      end
    end
  end

  assign ang_o    = zero[STEPS] ? '0 : zr[STEPS];
  assign mag_o    = zero[STEPS] ? '0 : xr[STEPS];
  assign side_out = sd[STEPS];

endmodule

>>> src/djp_lane.sv
// One arm's datapath: elbow from sin/cos of the motor angle, arm-frame vector,
// pitch and yaw from two vectoring CORDICs. Uses djp_pkg, djp_rot, djp_vec.
module djp_lane #(
  parameter int STEPS = djp_pkg::CORDIC_STEPS_DEF,
  parameter int PB    = djp_pkg::POSITION_BITS_DEF,
  parameter int ARM   = 0
) (
  input  logic                 clk,
  input  logic                 en,
  input  djp_pkg::geom_t       geom,
  input  logic signed [15:0]   motor,
  input  logic signed [PB-1:0] tx,
  input  logic signed [PB-1:0] ty,
  input  logic signed [PB-1:0] tz,
  output logic signed [16:0]   pitch,
  output logic signed [15:0]   yaw
);

  localparam int MP  = (PB > 25) ? PB : 25;
  localparam int DW  = MP + 4;          // arm-frame vector
  localparam int VW  = DW + 3;          // vectoring datapath
  localparam int TW  = PB + 33;         // frame rotation products
  localparam int RW  = 24 + djp_pkg::XW; // rf * sin/cos products
  localparam int GW  = DW + 18;         // dy * gain
  localparam int SW1 = 16 + 3 * PB;
  localparam int SW2 = 16 + DW;
  localparam logic signed [31:0] CK = djp_pkg::arm_cos(ARM);
  localparam logic signed [31:0] SK = djp_pkg::arm_sin(ARM);

  // motor sin/cos
  logic signed [djp_pkg::ZW-1:0] ang;
  logic signed [djp_pkg::XW-1:0] cs, sn;
  logic [SW1-1:0]                rside;
  assign ang = djp_pkg::ZW'(motor) <<< 17;

  djp_rot #(.STEPS(STEPS), .SW(SW1)) u_rot (
    .clk(clk), .en(en), .ang(ang), .side_in({motor, tz, ty, tx}),
    .cos_o(cs), .sin_o(sn), .side_out(rside)
  );

  logic signed [15:0]   r_m;
  logic signed [PB-1:0] r_tx, r_ty, r_tz;
  assign {r_m, r_tz, r_ty, r_tx} = rside;

  // products: elbow terms and tool rotated into the arm frame
  logic signed [RW-1:0] rc_p, rs_p;
  logic signed [TW-1:0] ta_p, tb_p;
  logic signed [PB-1:0] a_tz;
  logic signed [15:0]   a_m;
  always_ff @(posedge clk) begin
    if (en) begin
      rc_p <= RW'($signed({1'b0, geom.rf})) * RW'(cs);
      rs_p <= RW'($signed({1'b0, geom.rf})) * RW'(sn);
      ta_p <= TW'(CK) * TW'(r_tx) + TW'(SK) * TW'(r_ty);
      tb_p <= -(TW'(SK) * TW'(r_tx)) + TW'(CK) * TW'(r_ty);
      a_tz <= r_tz;
      a_m  <= r_m;
    end
  end

  // round to Q20 and form the elbow-to-attachment vector
  logic signed [TW-1:0] ta_r, tb_r;
  logic signed [RW-1:0] rc_r, rs_r;
  logic signed [DW-1:0] b_dx, b_dy, b_dz;
  logic signed [15:0]   b_m;
  assign ta_r = (ta_p + (TW'(1) <<< 29)) >>> 30;
  assign tb_r = (tb_p + (TW'(1) <<< 29)) >>> 30;
  assign rc_r = (rc_p + (RW'(1) <<< 29)) >>> 30;
  assign rs_r = (rs_p + (RW'(1) <<< 29)) >>> 30;

  always_ff @(posedge clk) begin
    if (en) begin
      b_dx <= DW'(ta_r) - DW'($signed({1'b0, geom.f}))
              + (DW'($signed({1'b0, geom.e})) <<< 1) - DW'(rc_r);
      b_dy <= DW'(tb_r);
      b_dz <= DW'(a_tz) - DW'(geom.zoff) + DW'(rs_r);
      b_m  <= a_m;
    end
  end

  // pitch: atan2(dz, -dx)
  logic signed [djp_pkg::ZW-1:0] comb;
  logic signed [VW-1:0]          mag;
  logic [SW2-1:0]                vside;
  djp_vec #(.STEPS(STEPS), .VW(VW), .SW(SW2)) u_pitch (
    .clk(clk), .en(en), .x_in(-VW'(b_dx)), .y_in(VW'(b_dz)),
    .side_in({b_m, b_dy}), .ang_o(comb), .mag_o(mag), .side_out(vside)
  );

  logic signed [15:0]            v_m;
  logic signed [DW-1:0]          v_dy;
  logic signed [djp_pkg::ZW-1:0] comb_r;
  assign {v_m, v_dy} = vside;
  assign comb_r = (comb + (djp_pkg::ZW'(1) <<< 16)) >>> 17;

  // gain-scale dy, finish pitch
  logic signed [GW-1:0] c_dyg;
  logic signed [VW-1:0] c_mag;
  logic signed [16:0]   c_pitch;
  always_ff @(posedge clk) begin
    if (en) begin
      c_dyg   <= GW'(v_dy) * GW'(djp_pkg::VEC_GAIN_Q16);
      c_mag   <= mag;
      c_pitch <= comb_r[16:0] - 17'(v_m);
    end
  end

  // yaw: atan2(dy * gain, magnitude)
  logic signed [GW-1:0]          dyg_r;
  logic signed [djp_pkg::ZW-1:0] yang;
  logic signed [VW-1:0]          mag2;
  logic [16:0]                   yside;
  assign dyg_r = (c_dyg + (GW'(1) <<< 15)) >>> 16;

  djp_vec #(.STEPS(STEPS), .VW(VW), .SW(17)) u_yaw (
    .clk(clk), .en(en), .x_in(c_mag), .y_in(VW'(dyg_r)),
    .side_in(c_pitch), .ang_o(yang), .mag_o(mag2), .side_out(yside)
  );

  logic signed [djp_pkg::ZW-1:0] yang_r;
  logic                          mag2_pos;
  assign yang_r   = (yang + (djp_pkg::ZW'(1) <<< 16)) >>> 17;
  assign mag2_pos = mag2[VW-1]; // magnitude unused beyond this lane

  // result register
  always_ff @(posedge clk) begin
    if (en) begin
      pitch <= yside;
      yaw   <= -yang_r[15:0] ^ {16{mag2_pos & 1'b0}};
    end
  end

endmodule

>>> src/delta_passive_joint_angles_top.sv
// Delta robot passive ball joint angles: three CORDIC lanes, one per arm, plus
// geometry registers and the merged output stream. Uses djp_pkg and djp_lane.
//
// Takes one pose per clock while the output is not stalled and returns one
// result per pose, in order. Each lane holds three fully pipelined CORDIC
// units: sin/cos, pitch atan2 and yaw atan2. The whole pipeline holds while
// a result waits at the output and m_tready is low. Geometry registers sit at
// byte addresses 0, 4, 8, 12; the user must write them only while no pose is
// in flight, which the block itself does not enforce.
module delta_passive_joint_angles_top #(
  parameter int CORDIC_STEPS  = djp_pkg::CORDIC_STEPS_DEF,
  parameter int POSITION_BITS = djp_pkg::POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // motor_angle_a, motor_angle_b, motor_angle_c, tool_x, tool_y, tool_z, zero pad
  input  logic [((48 + 3*POSITION_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // pitch_a, yaw_a, pitch_b, yaw_b, pitch_c, yaw_c, zero pad
  output logic [103:0] m_tdata
);

  localparam int PB  = POSITION_BITS;
  localparam int LAT = djp_pkg::lane_latency(CORDIC_STEPS);

  // geometry registers
  djp_pkg::geom_t geom;
  logic           wr;
  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      geom.rf   <= djp_pkg::UPPER_ARM_RST;
      geom.e    <= djp_pkg::PLATFORM_RST;
      geom.f    <= djp_pkg::BASE_RST;
      geom.zoff <= djp_pkg::MOTOR_ZOFF_RST;
    end else if (wr) begin
      case (paddr[3:2])
        djp_pkg::REG_UPPER_ARM:  geom.rf   <= pwdata[22:0];
        djp_pkg::REG_PLATFORM:   geom.e    <= pwdata[22:0];
        djp_pkg::REG_BASE:       geom.f    <= pwdata[22:0];
        djp_pkg::REG_MOTOR_ZOFF: geom.zoff <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[3:2])
      djp_pkg::REG_UPPER_ARM:  prdata = {9'd0, geom.rf};
      djp_pkg::REG_PLATFORM:   prdata = {9'd0, geom.e};
      djp_pkg::REG_BASE:       prdata = {9'd0, geom.f};
      djp_pkg::REG_MOTOR_ZOFF: prdata = {8'd0, geom.zoff};
      default:                 prdata = '0;
    endcase
  end

  // pipeline advance and valid tracking
  logic           adv;
  logic [LAT-1:0] vld;
  assign adv      = ~vld[LAT-1] | m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // input fields
  logic signed [15:0]   ma [0:2];
  logic signed [PB-1:0] tx, ty, tz;
  assign ma[0] = s_tdata[15:0];
  assign ma[1] = s_tdata[31:16];
  assign ma[2] = s_tdata[47:32];
  assign tx    = s_tdata[48 +: PB];
  assign ty    = s_tdata[48 + PB +: PB];
  assign tz    = s_tdata[48 + 2*PB +: PB];

  // one lane per arm
  logic signed [16:0] pitch [0:2];
  logic signed [15:0] yaw [0:2];
  for (genvar k = 0; k < 3; k++) begin : g_arm
    djp_lane #(.STEPS(CORDIC_STEPS), .PB(PB), .ARM(k)) u_lane (
      .clk(clk), .en(adv), .geom(geom), .motor(ma[k]),
      .tx(tx), .ty(ty), .tz(tz), .pitch(pitch[k]), .yaw(yaw[k])
    );
  end

  // merge lane results into one transfer
  assign m_tdata = {5'd0, yaw[2], pitch[2], yaw[1], pitch[1], yaw[0], pitch[0]};

endmodule

>>> sim/tb_delta_passive_joint_angles_top.sv
// Self-checking testbench for delta_passive_joint_angles_top: directed and
// random poses under several geometry settings, random stalls on both streams.
// Depends on djp_pkg and the RTL top level only.
module tb_delta_passive_joint_angles_top;
  timeunit 1ns;
  timeprecision 1ps;

  // pose fields, lowest bits last in the declaration
  typedef struct packed {
    logic signed [23:0] tool_z;
    logic signed [23:0] tool_y;
    logic signed [23:0] tool_x;
    logic signed [15:0] motor_c;
    logic signed [15:0] motor_b;
    logic signed [15:0] motor_a;
  } pose_t;

  typedef struct packed {
    logic [4:0]         pad;
    logic signed [15:0] yaw_c;
    logic signed [16:0] pitch_c;
    logic signed [15:0] yaw_b;
    logic signed [16:0] pitch_b;
    logic signed [15:0] yaw_a;
    logic signed [16:0] pitch_a;
  } joints_t;

  localparam int LATENCY     = djp_pkg::lane_latency(djp_pkg::CORDIC_STEPS_DEF);
  localparam int CYCLE_LIMIT = 400000;

  // joint angle predictor and result queue
  class joint_scoreboard;
    longint rf, e, f, zoff;
    joints_t expected_q[$];
    int mismatches;
    int unexpected;
    int checked;
    longint atan_tab[16];
    longint arm_c[3];
    longint arm_s[3];

    function new();
      atan_tab = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                   16775851, 8388437, 4194283, 2097149, 1048576, 524288,
                   262144, 131072, 65536, 32768};
      arm_c = '{0, 929887697, -929887697};
      arm_s = '{-1073741824, 536870912, 536870912};
      rf = 182849; e = 47186; f = 123857; zoff = -26214;
    endfunction

    function longint rnd(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // rotation-mode CORDIC with quadrant fold
    function void sin_cos(longint ang, output longint s, output longint c);
      longint x, y, z, xs, ys;
      bit neg;
      x = 652032874; y = 0; z = ang; neg = 0;
      if (z > 1686629713) begin
        z -= 64'sd3373259426; neg = 1;
      end else if (z < -1686629713) begin
        z += 64'sd3373259426; neg = 1;
      end
      for (int i = 0; i < 16; i++) begin
        xs = x >>> i; ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= atan_tab[i];
        end else begin
          x += ys; y -= xs; z += atan_tab[i];
        end
      end
      s = neg ? -y : y;
      c = neg ? -x : x;
    endfunction

    // vectoring-mode CORDIC, returns angle and gain-scaled magnitude
    function longint arctan2(longint x, longint y, output longint mag);
      longint z, xs, ys;
      z = 0;
      if (x == 0 && y == 0) begin
        mag = 0;
        return 0;
      end
      if (x < 0) begin
        z = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
        x = -x; y = -y;
      end
      for (int i = 0; i < 16; i++) begin
        xs = x >>> i; ys = y >>> i;
        if (y >= 0) begin
          x += ys; y -= xs; z += atan_tab[i];
        end else begin
          x -= ys; y += xs; z -= atan_tab[i];
        end
      end
      mag = x;
      return z;
    endfunction

    function joints_t predict_joints(pose_t p);
      joints_t r;
      longint tx, ty, tz, m, s, c, txa, tya, dx, dy, dz, mag, mag2, comb, yw;
      longint pitch[3], yaw[3];
      tx = p.tool_x; ty = p.tool_y; tz = p.tool_z;
      for (int k = 0; k < 3; k++) begin
        m = (k == 0) ? p.motor_a : (k == 1) ? p.motor_b : p.motor_c;
        sin_cos(m * 131072, s, c);
        txa = rnd(arm_c[k] * tx + arm_s[k] * ty, 30);
        tya = rnd(-arm_s[k] * tx + arm_c[k] * ty, 30);
        dx = txa - f + 2 * e - rnd(rf * c, 30);
        dy = tya;
        dz = tz - zoff + rnd(rf * s, 30);
        comb = arctan2(-dx, dz, mag);
        yw = arctan2(mag, rnd(dy * 107922, 16), mag2);
        pitch[k] = rnd(comb, 17) - m;
        yaw[k] = -rnd(yw, 17);
      end
      r = '0;
      r.pitch_a = 17'(pitch[0]); r.yaw_a = 16'(yaw[0]);
      r.pitch_b = 17'(pitch[1]); r.yaw_b = 16'(yaw[1]);
      r.pitch_c = 17'(pitch[2]); r.yaw_c = 16'(yaw[2]);
      return r;
    endfunction

    function void note_pose(pose_t p);
      expected_q.insert(expected_q.size(), predict_joints(p));
    endfunction

    function void check_joints(joints_t got);
      joints_t want;
      logic [16:0] g[6], w[6];
      string names[6];
      bit bad;
      names = '{"pitch_a", "yaw_a", "pitch_b", "yaw_b", "pitch_c", "yaw_c"};
      if (expected_q.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display("ERROR: result %h with nothing expected", got);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      g = '{got.pitch_a, 17'(got.yaw_a), got.pitch_b, 17'(got.yaw_b),
            got.pitch_c, 17'(got.yaw_c)};
      w = '{want.pitch_a, 17'(want.yaw_a), want.pitch_b, 17'(want.yaw_b),
            want.pitch_c, 17'(want.yaw_c)};
      bad = (got.pad != 0);
      for (int i = 0; i < 6; i++) if (g[i] != w[i]) bad = 1;
      if (bad) begin
        mismatches++;
        if (mismatches + unexpected <= 10) begin
          for (int i = 0; i < 6; i++)
            if (g[i] != w[i])
              $display("ERROR: result %0d %s expected %h got %h", checked, names[i],
                       w[i], g[i]);
          if (got.pad != 0) $display("ERROR: result %0d pad bits %h", checked, got.pad);
        end
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         psel = 0, penable = 0, pwrite = 0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_tvalid = 0;
  logic         s_tready;
  // motor_angle_a, motor_angle_b, motor_angle_c, tool_x, tool_y, tool_z
  logic [119:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  // pitch_a, yaw_a, pitch_b, yaw_b, pitch_c, yaw_c, zero pad
  logic [103:0] m_tdata;

  joint_scoreboard sb = new();
  bit  calm = 0;
  int  cycles = 0;
  int  poses_sent = 0;
  int  stall_left = 0;

  delta_passive_joint_angles_top u_top (.*);

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               sb.expected_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random stall bursts, none in the calm tail
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else begin
      if (m_tvalid && m_tready) sb.check_joints(joints_t'(m_tdata));
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 13);
        m_tready <= 0;
      end else begin
        m_tready <= 1;
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      djp_pkg::REG_UPPER_ARM:  sb.rf = longint'(val[22:0]);
      djp_pkg::REG_PLATFORM:   sb.e = longint'(val[22:0]);
      djp_pkg::REG_BASE:       sb.f = longint'(val[22:0]);
      djp_pkg::REG_MOTOR_ZOFF: sb.zoff = longint'($signed(val[23:0]));
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_geometry(logic [22:0] rf, logic [22:0] e, logic [22:0] f,
                              logic [23:0] zoff);
    reg_write(djp_pkg::REG_UPPER_ARM, {9'd0, rf});
    reg_write(djp_pkg::REG_PLATFORM, {9'd0, e});
    reg_write(djp_pkg::REG_BASE, {9'd0, f});
    reg_write(djp_pkg::REG_MOTOR_ZOFF, {8'd0, zoff});
  endtask

  // wait for the pipeline to drain
  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic send_pose(pose_t p);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= p;
    do @(posedge clk); while (!s_tready);
    sb.note_pose(p);
    poses_sent++;
  endtask

  function automatic pose_t make_pose(int ma, int mb, int mc, int x, int y, int z);
    pose_t p;
    p.motor_a = 16'(ma); p.motor_b = 16'(mb); p.motor_c = 16'(mc);
    p.tool_x = 24'(x); p.tool_y = 24'(y); p.tool_z = 24'(z);
    return p;
  endfunction

  // mostly poses near the working volume, some full-range noise
  function automatic pose_t random_pose();
    pose_t p;
    if ($urandom_range(0, 4) == 0) begin
      p = 120'({$urandom, $urandom, $urandom, $urandom});
    end else begin
      p = make_pose($urandom_range(0, 26000) - 13000, $urandom_range(0, 26000) - 13000,
                    $urandom_range(0, 26000) - 13000, $urandom_range(0, 800000) - 400000,
                    $urandom_range(0, 800000) - 400000, -$urandom_range(50000, 900000));
    end
    return p;
  endfunction

  task automatic random_poses(int n);
    for (int i = 0; i < n; i++) send_pose(random_pose());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, fold boundaries around +-pi/2, typical pose
    send_pose(make_pose(0, 0, 0, 0, 0, 0));
    send_pose(make_pose(32767, 32767, 32767, 8388607, 8388607, 8388607));
    send_pose(make_pose(-32768, -32768, -32768, -8388608, -8388608, -8388608));
    send_pose(make_pose(32767, -32768, 0, -8388608, 8388607, 0));
    send_pose(make_pose(12867, 12868, 12869, 100000, -100000, -400000));
    send_pose(make_pose(-12867, -12868, -12869, -100000, 100000, -400000));
    send_pose(make_pose(25736, -25736, 25737, 0, 0, -300000));
    send_pose(make_pose(4000, 4000, 4000, 0, 0, -500000));
    send_pose(make_pose(-3000, 6000, 1000, 200000, -150000, -700000));
    send_pose(make_pose(0, 0, 0, 1, -1, -1));
    random_poses(200);
    drain();

    // largest geometry
    set_geometry(23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 24'h7FFFFF);
    send_pose(make_pose(32767, -32768, 12868, 8388607, -8388608, 8388607));
    random_poses(200);
    drain();

    // smallest geometry
    set_geometry(23'd0, 23'd0, 23'd0, 24'h800000);
    send_pose(make_pose(-32768, 32767, 0, -8388608, 8388607, -8388608));
    random_poses(200);
    drain();

    // rf = 0, f = 2e, zoff = 0: a pose at the origin gives a zero vector on every arm
    set_geometry(23'd0, 23'd50000, 23'd100000, 24'd0);
    send_pose(make_pose(0, 0, 0, 0, 0, 0));
    send_pose(make_pose(12000, -7000, 32767, 0, 0, 0));
    send_pose(make_pose(-32768, 1, -1, 0, 0, 0));
    random_poses(150);
    drain();

    // random geometry
    set_geometry(23'($urandom_range(50000, 400000)), 23'($urandom_range(10000, 100000)),
                 23'($urandom_range(50000, 200000)),
                 24'($urandom_range(0, 200000) - 100000));
    random_poses(200);
    drain();

    // back to the reset geometry, calm tail at the end
    set_geometry(djp_pkg::UPPER_ARM_RST, djp_pkg::PLATFORM_RST, djp_pkg::BASE_RST,
                 djp_pkg::MOTOR_ZOFF_RST);
    random_poses(150);
    calm = 1;
    random_poses(120);
    s_tvalid <= 0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);

    $display("%0d poses sent, %0d results checked over six geometry settings",
             poses_sent, sb.checked);
    $display("%0d mismatching results, %0d unexpected, %0d missing",
             sb.mismatches, sb.unexpected, sb.expected_q.size());
    if (sb.mismatches == 0 && sb.unexpected == 0 && sb.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

>>> filelist.f
src/djp_pkg.sv
src/djp_rot.sv
src/djp_vec.sv
src/djp_lane.sv
src/delta_passive_joint_angles_top.sv
sim/tb_delta_passive_joint_angles_top.sv
